>>> hw/rtl/lpht_pkg.sv
// Package for the linear probe hash table: slot states, operation and status codes.
// No dependencies; used by every module of the block.
`default_nettype none
package lpht_pkg;
   localparam int unsigned KeyWidth = 64;
   localparam int unsigned LenWidth = 4;
   localparam int unsigned SizeWidth = 9;
   localparam int unsigned IndexWidth = 9;

   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_OCCUPIED = 2'd1,
      SLOT_DELETED  = 2'd2
   } slot_state_type;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic [IndexWidth-1:0] NO_SLOT = '1;
endpackage
`default_nettype wire

>>> hw/rtl/lpht_hash.sv
// Home slot unit: byte sum of the masked key, then reduction modulo the table size
// by shifted compare and subtract, four steps a cycle. Uses lpht_pkg.
`default_nettype none
module lpht_hash #(
   parameter int unsigned KEY_BYTES = 8,
   parameter int unsigned ADDR_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpht_pkg::KeyWidth-1:0]     key,
   input  logic [lpht_pkg::LenWidth-1:0]     len,
   input  logic [ADDR_W:0]                   size,
   output logic                              done,
   output logic [ADDR_W-1:0]                 home
);
   localparam int SumW = 11;
   localparam int StepsPerCycle = 4;
   localparam int LastStep = (SumW + StepsPerCycle - 1) / StepsPerCycle - 1;
   localparam int WideW = SumW + int'(ADDR_W) + 1;
   logic [SumW-1:0]  sum;
   logic [SumW-1:0]  rem_ff, rem_in;
   logic [1:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WideW-1:0] rem_wide;
   logic [WideW-1:0] trial;

   always_comb begin
      sum = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (i < int'(len)) begin
            sum = sum + SumW'(key[i*8 +: 8]);
         end
      end
   end

   // Sum is below 2048, so the quotient needs eleven bits: the size is tried at
   // shifts ten down to zero, four shifts per cycle, and the remainder is kept.
   always_comb begin
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_wide = WideW'(rem_ff);
      trial = '0;
      if (start) begin
         rem_in = sum;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int j = 0; j < StepsPerCycle; j++) begin
            if (int'(step_ff) * StepsPerCycle + j < SumW) begin
               trial = WideW'(size) << (SumW - 1 - (int'(step_ff) * StepsPerCycle + j));
               if (rem_wide >= trial) rem_wide = rem_wide - trial;
            end
         end
         rem_in = rem_wide[SumW-1:0];
         if (step_ff == 2'(LastStep)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign home = rem_ff[ADDR_W-1:0];
endmodule
`default_nettype wire

>>> hw/rtl/lpht_slot_mem.sv
// Slot store: key, key length and slot state in separate synchronous memories with
// registered read data; state entries are cleared by a sweep after reset. Uses lpht_pkg.
`default_nettype none
module lpht_slot_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [lpht_pkg::KeyWidth-1:0]  rd_key,
   output logic [lpht_pkg::LenWidth-1:0]  rd_len,
   output lpht_pkg::slot_state_type       rd_state,
   input  logic                           wr_en,
   input  logic                           wr_key_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [lpht_pkg::KeyWidth-1:0]  wr_key,
   input  logic [lpht_pkg::LenWidth-1:0]  wr_len,
   input  lpht_pkg::slot_state_type       wr_state,
   output logic                           clear_done
);
   logic [lpht_pkg::KeyWidth-1:0] key_mem [DEPTH];
   logic [lpht_pkg::LenWidth-1:0] len_mem [DEPTH];
   logic [1:0]                    st_mem  [DEPTH];
   logic [ADDR_W:0]               clr_ff;
   logic                          clearing;
   logic [1:0]                    st_rd_ff;

   assign clearing = (clr_ff != (ADDR_W+1)'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         st_mem[clr_ff[ADDR_W-1:0]] <= lpht_pkg::SLOT_EMPTY;
      end else if (wr_en) begin
         st_mem[wr_addr] <= wr_state;
      end
      st_rd_ff <= st_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_key_en && !clearing) begin
         key_mem[wr_addr] <= wr_key;
         len_mem[wr_addr] <= wr_len;
      end
      rd_key <= key_mem[rd_addr];
      rd_len <= len_mem[rd_addr];
   end

   assign rd_state = lpht_pkg::slot_state_type'(st_rd_ff);
   assign clear_done = !clearing;
endmodule
`default_nettype wire

>>> hw/rtl/linear_probe_hash_table.sv
// Linear probe hash table. An item passes through hashing (modulo reduction, then the
// hand-over of the home slot), then for each probed slot through issue read, memory
// latency, compare and write back, and then presents its result until it is taken;
// an operation code outside add, search and remove skips hashing and probing. The
// block returns to idle before the next request beat. One item is in flight at a
// time. After reset a clearing pass empties the slot states; no request is taken
// meanwhile, while csr writes are. The result waits in an output register.
`default_nettype none
module linear_probe_hash_table #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned KEY_BYTES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [lpht_pkg::KeyWidth-1:0]        req_key_bytes,
   input  logic [lpht_pkg::LenWidth-1:0]        req_key_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic signed [lpht_pkg::IndexWidth-1:0] rsp_slot_index,
   input  logic                                 csr_write,
   input  logic [lpht_pkg::SizeWidth-1:0]       csr_data
);
   localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [2:0] {IDLE, HASH, READ, WAIT, CHECK, RESP} state_type;

   state_type                       state_ff;
   logic [lpht_pkg::SizeWidth-1:0]  size_reg_ff;
   logic [AddrW:0]                  size;
   logic [1:0]                      op_ff;
   logic [lpht_pkg::KeyWidth-1:0]   key_ff;
   logic [lpht_pkg::LenWidth-1:0]   len_ff;
   logic [lpht_pkg::KeyWidth-1:0]   key_in;
   logic [lpht_pkg::LenWidth-1:0]   len_in;
   logic [AddrW-1:0]                idx_ff;
   logic [AddrW:0]                  count_ff;
   logic [1:0]                      status_ff;
   logic [lpht_pkg::IndexWidth-1:0] slot_ff;
   logic                            hash_done;
   logic [AddrW-1:0]                home;
   logic [lpht_pkg::KeyWidth-1:0]   rd_key;
   logic [lpht_pkg::LenWidth-1:0]   rd_len;
   lpht_pkg::slot_state_type        rd_state;
   logic                            wr_en;
   logic                            wr_key_en;
   lpht_pkg::slot_state_type        wr_state;
   logic                            clear_done;
   logic                            accept;
   logic                            hit;
   logic [AddrW-1:0]                idx_next;

   // Effective size: zero reads as one, anything above the depth saturates.
   always_comb begin
      if (size_reg_ff == '0) begin
         size = (AddrW+1)'(1);
      end else if (32'(size_reg_ff) > TABLE_DEPTH) begin
         size = (AddrW+1)'(TABLE_DEPTH);
      end else begin
         size = (AddrW+1)'(size_reg_ff);
      end
   end

   always_comb begin
      len_in = req_key_length;
      if (len_in == '0) len_in = 4'd1;
      if (32'(len_in) > KEY_BYTES) len_in = 4'(KEY_BYTES);
      key_in = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(len_in)) key_in[i*8 +: 8] = req_key_bytes[i*8 +: 8];
      end
   end

   assign req_ready = (state_ff == IDLE) && clear_done;
   assign accept = req_valid && req_ready;

   lpht_hash #(.KEY_BYTES(KEY_BYTES), .ADDR_W(AddrW)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (key_in),
      .len   (len_in),
      .size  (size),
      .done  (hash_done),
      .home  (home)
   );

   assign hit = (rd_state == lpht_pkg::SLOT_OCCUPIED) && (rd_len == len_ff)
      && (rd_key == key_ff);
   assign idx_next = ((AddrW+1)'(idx_ff) + 1'b1 == size) ? '0 : idx_ff + 1'b1;

   always_comb begin
      wr_en = 1'b0;
      wr_key_en = 1'b0;
      wr_state = lpht_pkg::SLOT_OCCUPIED;
      if (state_ff == CHECK) begin
         if (op_ff == lpht_pkg::OP_ADD && rd_state != lpht_pkg::SLOT_OCCUPIED) begin
            wr_en = 1'b1;
            wr_key_en = 1'b1;
         end else if (op_ff == lpht_pkg::OP_REMOVE && hit) begin
            wr_en = 1'b1;
            wr_state = lpht_pkg::SLOT_DELETED;
         end
      end
   end

   lpht_slot_mem #(.DEPTH(TABLE_DEPTH), .ADDR_W(AddrW)) u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (idx_ff),
      .rd_key     (rd_key),
      .rd_len     (rd_len),
      .rd_state   (rd_state),
      .wr_en      (wr_en),
      .wr_key_en  (wr_key_en),
      .wr_addr    (idx_ff),
      .wr_key     (key_ff),
      .wr_len     (len_ff),
      .wr_state   (wr_state),
      .clear_done (clear_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         size_reg_ff <= 9'd256;
      end else begin
         if (csr_write) size_reg_ff <= csr_data;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  op_ff <= req_operation;
                  key_ff <= key_in;
                  len_ff <= len_in;
                  count_ff <= '0;
                  status_ff <= lpht_pkg::STATUS_NOT_FOUND;
                  slot_ff <= lpht_pkg::NO_SLOT;
                  if (req_operation == lpht_pkg::OP_ADD || req_operation == lpht_pkg::OP_SEARCH
                      || req_operation == lpht_pkg::OP_REMOVE) begin
                     state_ff <= HASH;
                  end else begin
                     state_ff <= RESP;
                  end
               end
            end
            HASH: begin
               if (hash_done) begin
                  idx_ff <= home;
                  state_ff <= READ;
               end
            end
            READ: state_ff <= WAIT;
            WAIT: state_ff <= CHECK;
            CHECK: begin
               priority if (op_ff == lpht_pkg::OP_ADD
                            && rd_state != lpht_pkg::SLOT_OCCUPIED) begin
                  status_ff <= lpht_pkg::STATUS_DONE;
                  slot_ff <= 9'(idx_ff);
                  state_ff <= RESP;
               end else if (op_ff != lpht_pkg::OP_ADD
                            && rd_state == lpht_pkg::SLOT_EMPTY) begin
                  state_ff <= RESP;
               end else if (op_ff != lpht_pkg::OP_ADD && hit) begin
                  status_ff <= lpht_pkg::STATUS_DONE;
                  slot_ff <= 9'(idx_ff);
                  state_ff <= RESP;
               end else if (count_ff + 1'b1 == size) begin
                  if (op_ff == lpht_pkg::OP_ADD) status_ff <= lpht_pkg::STATUS_FULL;
                  state_ff <= RESP;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  idx_ff <= idx_next;
                  state_ff <= READ;
               end
            end
            RESP: if (rsp_ready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == RESP);
   assign rsp_status = status_ff;
   assign rsp_slot_index = slot_ff;
endmodule
`default_nettype wire

>>> hw/rtl/lpht_checker.sv
// Port-level checker for the linear probe hash table, bound to the top level.
// Depends on the top level's ports and the status codes of lpht_pkg.
`default_nettype none
module lpht_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_slot_index
);
   // One item in flight: no request beat while a response waits.
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lpht_pkg::STATUS_DONE |-> rsp_slot_index == lpht_pkg::NO_SLOT)
      else $error("failed operation reports a slot");
   a_ok_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lpht_pkg::STATUS_DONE |-> !rsp_slot_index[8])
      else $error("successful operation without slot");
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index)
);
`default_nettype wire

>>> test/tb_linear_probe_hash_table.sv
// Self-checking testbench for linear_probe_hash_table: directed table, then random phases.
// Depends on lpht_pkg and the linear_probe_hash_table RTL only.
`default_nettype none
module tb_linear_probe_hash_table;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [63:0] req_key_bytes;
   logic [3:0]  req_key_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic signed [8:0] rsp_slot_index;
   logic        csr_write;
   logic [8:0]  csr_data;

   linear_probe_hash_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_key_bytes(req_key_bytes), .req_key_length(req_key_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index), .csr_write(csr_write), .csr_data(csr_data)
   );

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] slot;
   } reply_type;

   typedef struct {
      bit          is_cfg;
      logic [8:0]  size;
      logic [1:0]  op;
      logic [63:0] key;
      logic [3:0]  len;
      bit          typed;
      logic [1:0]  status;
      logic [8:0]  slot;
   } script_row_type;

   // Mirror of the table contents.
   logic [63:0]              mirror_key [256];
   logic [3:0]               mirror_len [256];
   lpht_pkg::slot_state_type mirror_state [256];
   logic [8:0]               mirror_size;

   reply_type      pending_replies [$];
   script_row_type script [$];
   logic [63:0]    key_pool [24];
   int             errors;
   bit             quiet;
   bit             long_hold;
   bit             fixed_valid;
   reply_type      fixed_reply;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic reply_type probe_table(input logic [1:0] op, input logic [63:0] key_in,
                                             input logic [3:0] len_in);
      int unsigned len, size, pos, sum, n;
      logic [63:0] key;
      reply_type r;
      len = (len_in == 0) ? 1 : ((len_in > 8) ? 8 : len_in);
      size = (mirror_size == 0) ? 1 : ((mirror_size > 256) ? 256 : mirror_size);
      key = (len == 8) ? key_in : key_in & ((64'd1 << (len * 8)) - 64'd1);
      sum = 0;
      for (n = 0; n < len; n++) sum += key[n*8 +: 8];
      pos = sum % size;
      r.status = lpht_pkg::STATUS_NOT_FOUND;
      r.slot = lpht_pkg::NO_SLOT;
      if (op == lpht_pkg::OP_ADD) begin
         r.status = lpht_pkg::STATUS_FULL;
         for (n = 0; n < size; n++) begin
            if (mirror_state[pos] != lpht_pkg::SLOT_OCCUPIED) begin
               mirror_key[pos] = key;
               mirror_len[pos] = 4'(len);
               mirror_state[pos] = lpht_pkg::SLOT_OCCUPIED;
               r.status = lpht_pkg::STATUS_DONE;
               r.slot = 9'(pos);
               break;
            end
            pos = (pos + 1) % size;
         end
      end else if (op == lpht_pkg::OP_SEARCH || op == lpht_pkg::OP_REMOVE) begin
         for (n = 0; n < size; n++) begin
            if (mirror_state[pos] == lpht_pkg::SLOT_EMPTY) break;
            if (mirror_state[pos] == lpht_pkg::SLOT_OCCUPIED && mirror_len[pos] == len &&
                mirror_key[pos] == key) begin
               if (op == lpht_pkg::OP_REMOVE) mirror_state[pos] = lpht_pkg::SLOT_DELETED;
               r.status = lpht_pkg::STATUS_DONE;
               r.slot = 9'(pos);
               break;
            end
            pos = (pos + 1) % size;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Request beat accepted: update the mirror and queue the expected reply.
   always @(posedge clock) begin
      reply_type r;
      if (!reset && req_valid && req_ready) begin
         r = probe_table(req_operation, req_key_bytes, req_key_length);
         pending_replies.push_back(fixed_valid ? fixed_reply : r);
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("outstanding replies", 0, 1);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_slot_index !== want.slot)
               report_mismatch("slot_index", rsp_slot_index, $signed(want.slot));
         end
      end
   end

   // Reply side back-pressure, with one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_ready = quiet || ($urandom_range(99) >= 16);
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [63:0] key,
                               input logic [3:0] len);
      while (!quiet && $urandom_range(99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_key_bytes = key;
      req_key_length = len;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_size(input logic [8:0] size);
      req_valid = 1'b0;
      wait (pending_replies.size() == 0);
      repeat (5) @(negedge clock);
      csr_write = 1'b1;
      csr_data = size;
      mirror_size = size;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic add_row(input bit is_cfg, input logic [8:0] size, input logic [1:0] op,
                          input logic [63:0] key, input logic [3:0] len, input bit typed,
                          input logic [1:0] status, input logic [8:0] slot);
      script_row_type row;
      row = '{is_cfg, size, op, key, len, typed, status, slot};
      script.push_back(row);
   endtask

   initial begin
      int phase, n, pick;
      logic [1:0] op;
      logic [3:0] len;
      logic [63:0] key;
      errors = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      fixed_valid = 1'b0;
      fixed_reply = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = lpht_pkg::OP_ADD;
      req_key_bytes = '0;
      req_key_length = 4'd1;
      csr_write = 1'b0;
      csr_data = '0;
      mirror_size = 9'd256;
      for (n = 0; n < 256; n++) begin
         mirror_state[n] = lpht_pkg::SLOT_EMPTY;
         mirror_key[n] = '0;
         mirror_len[n] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table after reset, extremes of key and length, odd codes.
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h41, 1, 1, lpht_pkg::STATUS_NOT_FOUND,
              lpht_pkg::NO_SLOT);
      add_row(0, 0, lpht_pkg::OP_REMOVE, 64'h41, 1, 1, lpht_pkg::STATUS_NOT_FOUND,
              lpht_pkg::NO_SLOT);
      add_row(0, 0, lpht_pkg::OP_ADD, '1, 8, 1, lpht_pkg::STATUS_DONE, 9'd248);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h0, 1, 1, lpht_pkg::STATUS_DONE, 9'd0);
      add_row(0, 0, lpht_pkg::OP_SEARCH, '1, 8, 1, lpht_pkg::STATUS_DONE, 9'd248);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FF01, 1, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h01, 0, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h0102_0304_0506_0702, 15, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h0102_0304_0506_0702, 8, 0, 0, 0);
      add_row(0, 0, 2'd3, 64'h0, 1, 1, lpht_pkg::STATUS_NOT_FOUND, lpht_pkg::NO_SLOT);
      add_row(0, 0, lpht_pkg::OP_REMOVE, 64'h0, 1, 1, lpht_pkg::STATUS_DONE, 9'd0);
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h0, 1, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h0, 2, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_REMOVE, '1, 8, 0, 0, 0);
      // Size zero acts as one slot, which is already taken: the table is full.
      add_row(1, 9'd0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h55, 3, 1, lpht_pkg::STATUS_FULL, lpht_pkg::NO_SLOT);
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h0, 2, 0, 0, 0);
      add_row(1, 9'd2, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h77, 1, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h78, 1, 0, 0, 0);
      // Oversized values saturate to the full depth; old slots are not rehashed.
      add_row(1, 9'd511, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_SEARCH, 64'h77, 1, 0, 0, 0);
      add_row(0, 0, lpht_pkg::OP_ADD, 64'h1234, 2, 0, 0, 0);

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            write_size(script[i].size);
         end else begin
            fixed_valid = script[i].typed;
            fixed_reply = '{script[i].status, script[i].slot};
            send_request(script[i].op, script[i].key, script[i].len);
         end
      end
      fixed_valid = 1'b0;

      for (phase = 0; phase < 18; phase++) begin
         case (phase % 9)
            0: write_size(9'd256);
            1: write_size(9'd1);
            2: write_size(9'd7);
            3: write_size(9'd16);
            4: write_size(9'd255);
            5: write_size(9'd64);
            6: write_size(9'd2);
            7: write_size(9'd128);
            default: write_size(9'd33);
         endcase
         quiet = (phase == 5);
         if (phase == 3) long_hold = 1'b1;
         // A small pool of keys makes hits, removals and full tables common.
         for (n = 0; n < 24; n++) key_pool[n] = {$urandom, $urandom};
         for (n = 0; n < ((phase % 9 == 1) ? 30 : 105); n++) begin
            pick = int'($urandom_range(99));
            len = 4'($urandom_range(1, 8));
            key = key_pool[$urandom_range(23)];
            if (pick < 40) op = lpht_pkg::OP_ADD;
            else if (pick < 72) op = lpht_pkg::OP_SEARCH;
            else if (pick < 93) op = lpht_pkg::OP_REMOVE;
            else begin
               op = 2'($urandom_range(3));
               len = 4'($urandom_range(15));
               key = {$urandom, $urandom};
            end
            if ($urandom_range(3) == 0) len = 4'(key_pool[n % 24][3:0] % 4 + 1);
            send_request(op, key, len);
         end
      end
      quiet = 1'b0;
      req_valid = 1'b0;
      wait (pending_replies.size() == 0);
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
